// ----- design/ldp_pkg.sv -----
// Package for the linkage descriptor parser: payload types, parse phases,
// field codes, register defaults and the phase helper functions.
// No dependencies.
package ldp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_value;
    typedef logic [1:0]  t_reg_index;
    typedef logic [3:0]  t_options;

    typedef enum logic [4:0] {
        FC_TS         = 5'd0,
        FC_ONID       = 5'd1,
        FC_SID        = 5'd2,
        FC_TYPE       = 5'd3,
        FC_HFLAGS     = 5'd4,
        FC_NET        = 5'd5,
        FC_INIT_SID   = 5'd6,
        FC_EVT_ID     = 5'd7,
        FC_EVT_FLAGS  = 5'd8,
        FC_LOOP_LEN   = 5'd9,
        FC_XEVT_ID    = 5'd10,
        FC_XFLAGS     = 5'd11,
        FC_USER_ID    = 5'd12,
        FC_XTS        = 5'd13,
        FC_XONID      = 5'd14,
        FC_XSID       = 5'd15,
        FC_PRIVATE    = 5'd16
    } t_field;

    typedef enum logic [27:0] {
        PH_TS_H    = 28'h1 << 0,
        PH_TS_L    = 28'h1 << 1,
        PH_ON_H    = 28'h1 << 2,
        PH_ON_L    = 28'h1 << 3,
        PH_SV_H    = 28'h1 << 4,
        PH_SV_L    = 28'h1 << 5,
        PH_TYPE    = 28'h1 << 6,
        PH_HFLAGS  = 28'h1 << 7,
        PH_NET_H   = 28'h1 << 8,
        PH_NET_L   = 28'h1 << 9,
        PH_INIT_H  = 28'h1 << 10,
        PH_INIT_L  = 28'h1 << 11,
        PH_EVT_H   = 28'h1 << 12,
        PH_EVT_L   = 28'h1 << 13,
        PH_EFLAGS  = 28'h1 << 14,
        PH_LOOPLEN = 28'h1 << 15,
        PH_XEVT_H  = 28'h1 << 16,
        PH_XEVT_L  = 28'h1 << 17,
        PH_XFLAGS  = 28'h1 << 18,
        PH_USER_H  = 28'h1 << 19,
        PH_USER_L  = 28'h1 << 20,
        PH_XTS_H   = 28'h1 << 21,
        PH_XTS_L   = 28'h1 << 22,
        PH_XON_H   = 28'h1 << 23,
        PH_XON_L   = 28'h1 << 24,
        PH_XSV_H   = 28'h1 << 25,
        PH_XSV_L   = 28'h1 << 26,
        PH_PRIV    = 28'h1 << 27
    } t_phase;

    // Phases that belong to an extended event loop entry.
    localparam logic [27:0] LOOP_MASK = 28'h7FF0000;

    localparam t_reg_index REG_HANDOVER = 2'd0;
    localparam t_reg_index REG_EVENT    = 2'd1;
    localparam t_reg_index REG_EXT_MIN  = 2'd2;
    localparam t_reg_index REG_EXT_MAX  = 2'd3;

    localparam t_byte HANDOVER_RESET = 8'd8;
    localparam t_byte EVENT_RESET    = 8'd13;
    localparam t_byte EXT_MIN_RESET  = 8'd14;
    localparam t_byte EXT_MAX_RESET  = 8'd31;

    typedef struct packed {
        t_byte handover_type_code;
        t_byte event_type_code;
        t_byte ext_event_min_code;
        t_byte ext_event_max_code;
    } t_cfg;

    typedef struct packed {
        logic   valid;
        t_field field_code;
        t_value field_value;
        logic   payload_done;
        logic   parse_error;
    } t_result;

    function automatic logic phase_in_loop(input t_phase ph);
        return |(ph & LOOP_MASK);
    endfunction

    function automatic t_phase next_handover(input t_options opts);
        if (opts[0]) begin
            return PH_NET_H;
        end else if (opts[1]) begin
            return PH_INIT_H;
        end
        return PH_PRIV;
    endfunction

    function automatic t_phase next_ext(input t_options opts, input t_byte left);
        if (opts[0]) begin
            return PH_USER_H;
        end else if (opts[1]) begin
            return PH_XTS_H;
        end else if (opts[2]) begin
            return PH_XON_H;
        end else if (opts[3]) begin
            return PH_XSV_H;
        end else if (left != 8'd0) begin
            return PH_XEVT_H;
        end
        return PH_PRIV;
    endfunction

    function automatic t_field phase_field(input t_phase ph);
        t_field f;
        unique case (ph)
            PH_TS_H, PH_TS_L:       f = FC_TS;
            PH_ON_H, PH_ON_L:       f = FC_ONID;
            PH_SV_H, PH_SV_L:       f = FC_SID;
            PH_TYPE:                f = FC_TYPE;
            PH_HFLAGS:              f = FC_HFLAGS;
            PH_NET_H, PH_NET_L:     f = FC_NET;
            PH_INIT_H, PH_INIT_L:   f = FC_INIT_SID;
            PH_EVT_H, PH_EVT_L:     f = FC_EVT_ID;
            PH_EFLAGS:              f = FC_EVT_FLAGS;
            PH_LOOPLEN:             f = FC_LOOP_LEN;
            PH_XEVT_H, PH_XEVT_L:   f = FC_XEVT_ID;
            PH_XFLAGS:              f = FC_XFLAGS;
            PH_USER_H, PH_USER_L:   f = FC_USER_ID;
            PH_XTS_H, PH_XTS_L:     f = FC_XTS;
            PH_XON_H, PH_XON_L:     f = FC_XONID;
            PH_XSV_H, PH_XSV_L:     f = FC_XSID;
            default:                f = FC_PRIVATE;
        endcase
        return f;
    endfunction

endpackage

// ----- design/ldp_ifs.sv -----
// Channel interfaces of the linkage descriptor parser: payload bytes in,
// parsed fields out, and register writes. Depends on ldp_pkg.
interface ldp_byte_if;
    logic           valid;
    logic           ready;
    ldp_pkg::t_byte data_byte;
    logic           end_of_payload;
    modport source (output valid, data_byte, end_of_payload, input ready);
    modport sink   (input valid, data_byte, end_of_payload, output ready);
endinterface

interface ldp_field_if;
    logic            valid;
    logic            ready;
    ldp_pkg::t_field field_code;
    ldp_pkg::t_value field_value;
    logic            payload_done;
    logic            parse_error;
    modport source (output valid, field_code, field_value, payload_done, parse_error,
                    input ready);
    modport sink   (input valid, field_code, field_value, payload_done, parse_error,
                    output ready);
endinterface

interface ldp_cfg_if;
    logic                valid;
    logic                ready;
    ldp_pkg::t_reg_index reg_index;
    ldp_pkg::t_byte      wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- design/ldp_cfg_regs.sv -----
// Register file holding the four linkage type codes of the parser.
// Depends on ldp_pkg and ldp_cfg_if.
module ldp_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ldp_cfg_if.sink       i_cfg,
    output ldp_pkg::t_cfg o_cfg
);
    import ldp_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.handover_type_code <= HANDOVER_RESET;
            r_cfg.event_type_code    <= EVENT_RESET;
            r_cfg.ext_event_min_code <= EXT_MIN_RESET;
            r_cfg.ext_event_max_code <= EXT_MAX_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_HANDOVER: r_cfg.handover_type_code <= i_cfg.wr_data;
                REG_EVENT:    r_cfg.event_type_code    <= i_cfg.wr_data;
                REG_EXT_MIN:  r_cfg.ext_event_min_code <= i_cfg.wr_data;
                REG_EXT_MAX:  r_cfg.ext_event_max_code <= i_cfg.wr_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

// ----- design/ldp_step.sv -----
// Parse state and next-state logic: takes one registered payload byte per
// enabled cycle and forms the result for it. Depends on ldp_pkg.
module ldp_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  ldp_pkg::t_byte   i_byte,
    input  logic             i_eop,
    input  ldp_pkg::t_cfg    i_cfg,
    output ldp_pkg::t_result o_result
);
    import ldp_pkg::*;

    t_phase   r_phase, n_phase;
    t_byte    r_hold, n_hold;
    t_options r_pend, n_pend;
    t_byte    r_left, n_left;
    logic     r_err, n_err;

    t_phase   nxt;
    t_value   value;
    logic     emit;
    logic     in_loop;
    logic     loop_err;

    always_comb begin
        n_hold   = r_hold;
        n_pend   = r_pend;
        n_left   = r_left;
        loop_err = r_err;
        value    = '0;
        emit     = 1'b0;
        nxt      = PH_PRIV;
        in_loop  = phase_in_loop(r_phase);

        if (in_loop) begin
            if (r_left != 8'd0) begin
                n_left = r_left - 8'd1;
            end else begin
                loop_err = 1'b1;
            end
        end

        unique case (r_phase)
            PH_TS_H, PH_ON_H, PH_SV_H, PH_NET_H, PH_INIT_H, PH_EVT_H,
            PH_XEVT_H, PH_USER_H, PH_XTS_H, PH_XON_H, PH_XSV_H: begin
                n_hold = i_byte;
                nxt    = t_phase'(r_phase << 1);
            end
            PH_TS_L, PH_ON_L, PH_SV_L, PH_EVT_L, PH_XEVT_L: begin
                value = {r_hold, i_byte};
                emit  = 1'b1;
                nxt   = t_phase'(r_phase << 1);
            end
            PH_TYPE: begin
                value = {8'd0, i_byte};
                emit  = 1'b1;
                if (i_byte == i_cfg.handover_type_code) begin
                    nxt = PH_HFLAGS;
                end else if (i_byte == i_cfg.event_type_code) begin
                    nxt = PH_EVT_H;
                end else if (i_byte >= i_cfg.ext_event_min_code &&
                             i_byte <= i_cfg.ext_event_max_code) begin
                    nxt = PH_LOOPLEN;
                end else begin
                    nxt = PH_PRIV;
                end
            end
            PH_HFLAGS: begin
                value  = {8'd0, i_byte};
                emit   = 1'b1;
                n_pend = {2'b00, ~i_byte[0],
                          (i_byte[7:4] >= 4'd1 && i_byte[7:4] <= 4'd3)};
                nxt    = next_handover(n_pend);
            end
            PH_NET_L, PH_INIT_L: begin
                value  = {r_hold, i_byte};
                emit   = 1'b1;
                n_pend = (r_phase == PH_NET_L) ? (r_pend & 4'b1110) : (r_pend & 4'b1101);
                nxt    = next_handover(n_pend);
            end
            PH_EFLAGS: begin
                value = {8'd0, i_byte};
                emit  = 1'b1;
                nxt   = PH_PRIV;
            end
            PH_LOOPLEN: begin
                value  = {8'd0, i_byte};
                emit   = 1'b1;
                n_left = i_byte;
                nxt    = (i_byte != 8'd0) ? PH_XEVT_H : PH_PRIV;
            end
            PH_XFLAGS: begin
                value = {8'd0, i_byte};
                emit  = 1'b1;
                if (i_byte[3:2] == 2'd3) begin
                    n_pend = 4'b0001;
                end else begin
                    n_pend = {i_byte[0], i_byte[1], (i_byte[3:2] == 2'd1), 1'b0};
                end
                nxt = next_ext(n_pend, n_left);
            end
            PH_USER_L, PH_XTS_L, PH_XON_L, PH_XSV_L: begin
                value = {r_hold, i_byte};
                emit  = 1'b1;
                if (r_phase == PH_USER_L) begin
                    n_pend = r_pend & 4'b1110;
                end else if (r_phase == PH_XTS_L) begin
                    n_pend = r_pend & 4'b1101;
                end else if (r_phase == PH_XON_L) begin
                    n_pend = r_pend & 4'b1011;
                end else begin
                    n_pend = r_pend & 4'b0111;
                end
                nxt = next_ext(n_pend, n_left);
            end
            default: begin
                value = {8'd0, i_byte};
                emit  = 1'b1;
                nxt   = PH_PRIV;
            end
        endcase

        // An entry that runs past the loop length ends the loop.
        n_err = loop_err;
        if (in_loop && n_left == 8'd0 && phase_in_loop(nxt)) begin
            n_err = 1'b1;
            nxt   = PH_PRIV;
        end
        n_phase = nxt;

        o_result.valid        = emit | i_eop;
        o_result.field_code   = phase_field(r_phase);
        o_result.field_value  = value;
        o_result.payload_done = i_eop;
        o_result.parse_error  = i_eop & (n_err | (nxt != PH_PRIV));

        if (i_eop) begin
            n_phase = PH_TS_H;
            n_hold  = '0;
            n_pend  = '0;
            n_left  = '0;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TS_H;
            r_hold  <= '0;
            r_pend  <= '0;
            r_left  <= '0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_pend  <= n_pend;
            r_left  <= n_left;
            r_err   <= n_err;
        end
    end

endmodule

// ----- design/linkage_descriptor_parser.sv -----
// Top level of the linkage descriptor parser: input register, parse step and
// result register. Depends on ldp_pkg, ldp_ifs, ldp_cfg_regs and ldp_step.
//
//   channel  direction  request carries
//   i_in     in         data_byte, end_of_payload
//   o_out    out        field_code, field_value, payload_done, parse_error
//   i_cfg    in         reg_index, wr_data (always ready)
//
// One payload byte is accepted per cycle while the result register is free or
// being taken; its result passes the input register, then the result register.
// A byte that completes no field and is not the final byte gives no result.
// Synchronous active-low reset returns the parser to the first fixed byte
// and the registers to their defaults.
// A stalled result holds the result register and the input register behind it.
module linkage_descriptor_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldp_byte_if.sink   i_in,
    ldp_field_if.source o_out,
    ldp_cfg_if.sink    i_cfg
);
    import ldp_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic    r_s1_valid;
    t_byte   r_s1_byte;
    logic    r_s1_eop;
    t_result r_out;

    logic    out_free;
    logic    step_go;

    assign out_free   = !r_out.valid || o_out.ready;
    assign step_go    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || step_go;

    ldp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ldp_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_go),
        .i_byte   (r_s1_byte),
        .i_eop    (r_s1_eop),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_eop  <= i_in.end_of_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (step_go) begin
            r_out <= result;
        end else if (o_out.ready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_out.valid;
    assign o_out.field_code   = r_out.field_code;
    assign o_out.field_value  = r_out.field_value;
    assign o_out.payload_done = r_out.payload_done;
    assign o_out.parse_error  = r_out.parse_error;

endmodule

// ----- design/ldp_checker.sv -----
// Port-level checks for the linkage descriptor parser and the bind that
// attaches them to the top level. Depends on ldp_pkg.
module ldp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input ldp_pkg::t_field i_field_code,
    input ldp_pkg::t_value i_field_value,
    input logic            i_payload_done,
    input logic            i_parse_error,
    input logic            i_cfg_ready
);
    import ldp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_field_code) &&
            $stable(i_field_value) && $stable(i_payload_done) && $stable(i_parse_error))
        else $error("stalled result changed");

    a_error_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_parse_error |-> i_payload_done)
        else $error("parse error reported before the final byte");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_field_code <= FC_PRIVATE)
        else $error("field code out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty result register");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write port not ready");

endmodule

bind linkage_descriptor_parser ldp_checker u_ldp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_field_code   (o_out.field_code),
    .i_field_value  (o_out.field_value),
    .i_payload_done (o_out.payload_done),
    .i_parse_error  (o_out.parse_error),
    .i_cfg_ready    (i_cfg.ready)
);
